// ===== rtl/tspat_pkg.sv =====
// Package for the transport stream PAT section parser.
// Holds status codes, result kinds, header constants, the output width and the byte-wide CRC-32 update.
// No dependencies.
`default_nettype none

package tspat_pkg;

  // status codes reported in the closing result of a buffer
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT_BUF  = 3'd1,
    ST_SYNTAX     = 3'd2,
    ST_TABLE_ID   = 3'd3,
    ST_SIZE       = 3'd4,
    ST_CRC        = 3'd5,
    ST_SHORT_LEN  = 3'd6
  } status_t;

  // result kinds, carried on tuser
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // header byte constants
  localparam logic [7:0] TABLE_ID_PAT  = 8'h00;
  localparam logic [7:0] SYNTAX_MASK   = 8'hC0;
  localparam logic [7:0] SYNTAX_VALUE  = 8'h80;
  localparam logic [7:0] LEN_HI_MASK   = 8'h0F;
  localparam logic [11:0] MIN_LENGTH   = 12'd5;
  localparam logic [12:0] MIN_BUF_IDX  = 13'd6;   // seventh byte has index 6
  localparam logic [12:0] FIRST_ENTRY_IDX = 13'd11;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int OUT_DATA_W = 88;

  // CRC-32/MPEG-2 update by one byte, MSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/transport_stream_pat_section_parser_core.sv =====
// Top level of the transport stream PAT section parser.
// Uses tspat_pkg for status codes, constants and the CRC-32 byte update.
// Byte-serial header, CRC and entry parsing with a registered result stage.
//
// Usage:
//   Input channel s_*: one section byte per transaction in s_tdata, s_tlast
//   marks the last byte of the supplied buffer.
//   Output channel m_*: m_tuser is the result kind (0 program entry, 1 status).
//   Each program entry is sent as soon as its fourth byte is taken; one status
//   result closes every buffer, at the section end, at an early error or at the buffer end.
//   Bytes after the status are dropped until the next s_tlast.
// Latency and throughput:
//   One byte per cycle while not stalled. A result appears on m_* in the cycle
//   after the byte that causes it. Parsing state and the CRC update by one byte
//   per cycle are all updated in the accept cycle; the result register is the only stage.
// Reset and stall:
//   rst clears all parsing state and m_tvalid. While the receiver
//   holds m_tready low with a result pending, s_tready drops; a taken result
//   frees the register in the same cycle, so no cycles are lost.
`default_nettype none

module transport_stream_pat_section_parser_core
  import tspat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] byte_in
  input  wire logic                  s_tlast,   // buffer_end
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [15:0] prog_num, [28:16] pid,
                                                // [44:29] stream_id, [49:45] version,
                                                // [50] current_next, [58:51] section_index,
                                                // [66:59] last_section_index,
                                                // [69:67] status, [82:70] consumed_bytes,
                                                // [87:83] zero
  output logic                       m_tuser    // kind
);

  // parsing state
  logic [12:0] byte_count;
  logic [11:0] length_field;
  logic [31:0] crc_register;
  logic [31:0] crc_trailer;
  logic [31:0] entry_shift;
  logic [39:0] header_latch;
  status_t     first_error;
  logic        finished;

  logic [12:0] byte_count_next;
  logic [11:0] length_field_next;
  logic [31:0] crc_register_next;
  logic [31:0] crc_trailer_next;
  logic [31:0] entry_shift_next;
  logic [39:0] header_latch_next;
  status_t     first_error_next;
  logic        finished_next;

  // result formed in the accept cycle
  logic                  res_valid;
  logic [OUT_DATA_W-1:0] res_data;
  logic                  res_kind;

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // per-byte decode
  logic [12:0] idx;
  logic [13:0] idx_plus1;
  logic [13:0] len_plus2;
  logic [12:0] consumed;
  logic        in_crc_span;
  logic        section_end;
  logic        entry_done;
  logic        early_err;
  status_t     end_code;
  status_t     code;
  logic [7:0]  vbyte;

  always_comb begin
    idx         = byte_count;
    idx_plus1   = {1'b0, idx} + 14'd1;
    len_plus2   = {2'b00, length_field} + 14'd2;
    consumed    = {1'b0, length_field} + 13'd3;

    byte_count_next   = idx + 13'd1;
    length_field_next = length_field;
    first_error_next  = first_error;
    header_latch_next = header_latch;
    finished_next     = finished;

    // header bytes
    if (idx == 13'd0) begin
      if (s_tdata != TABLE_ID_PAT) begin
        first_error_next = ST_TABLE_ID;
      end
    end else if (idx == 13'd1) begin
      if ((s_tdata & SYNTAX_MASK) != SYNTAX_VALUE) begin
        first_error_next = ST_SYNTAX;
      end
      length_field_next = {s_tdata[3:0] & LEN_HI_MASK[3:0], 8'd0};
    end else if (idx == 13'd2) begin
      length_field_next = {length_field[11:8], s_tdata};
      if (first_error == ST_OK && {length_field[11:8], s_tdata} < MIN_LENGTH) begin
        first_error_next = ST_SHORT_LEN;
      end
    end else if (idx <= 13'd7) begin
      header_latch_next = {header_latch[31:0], s_tdata};
    end

    // CRC over the body, trailer capture after it
    in_crc_span       = (idx < 13'd3) || (idx_plus1 < {2'b00, length_field});
    crc_register_next = crc_register;
    crc_trailer_next  = crc_trailer;
    if (in_crc_span) begin
      crc_register_next = crc_byte(crc_register, s_tdata);
    end else begin
      crc_trailer_next = {crc_trailer[23:0], s_tdata};
    end
    entry_shift_next = {entry_shift[23:0], s_tdata};

    // result decisions
    section_end = (first_error_next == ST_OK) && (idx >= 13'd3) &&
                  ({1'b0, idx} == len_plus2);
    early_err   = (first_error_next != ST_OK) && (idx >= MIN_BUF_IDX);
    entry_done  = (first_error_next == ST_OK) && (idx >= FIRST_ENTRY_IDX) &&
                  (idx[1:0] == 2'b11) && ((idx - 13'd2) < {1'b0, length_field});

    if (idx < MIN_BUF_IDX) begin
      end_code = ST_SHORT_BUF;
    end else if (first_error_next != ST_OK) begin
      end_code = first_error_next;
    end else begin
      end_code = ST_SIZE;
    end

    // trailer is not in the CRC span here, so the register is already final
    code = (crc_trailer_next == crc_register) ? ST_OK : ST_CRC;
    if (!section_end) begin
      code = s_tlast ? end_code : first_error_next;
    end

    vbyte     = header_latch_next[23:16];
    res_valid = 1'b0;
    res_kind  = KIND_ENTRY;
    res_data  = '0;
    if (section_end || s_tlast || early_err) begin
      res_valid           = 1'b1;
      res_kind            = KIND_STATUS;
      res_data[69:67]     = code;
      if (code == ST_OK) begin
        res_data[44:29] = header_latch_next[39:24];
        res_data[49:45] = vbyte[5:1];
        res_data[50]    = vbyte[0];
        res_data[58:51] = header_latch_next[15:8];
        res_data[66:59] = header_latch_next[7:0];
        res_data[82:70] = consumed;
      end
      finished_next = 1'b1;
    end else if (entry_done) begin
      res_valid       = 1'b1;
      res_data[15:0]  = entry_shift_next[31:16];
      res_data[28:16] = entry_shift_next[12:0];
    end

    // bytes after a status are ignored
    if (finished) begin
      res_valid         = 1'b0;
      byte_count_next   = byte_count;
      length_field_next = length_field;
      crc_register_next = crc_register;
      crc_trailer_next  = crc_trailer;
      entry_shift_next  = entry_shift;
      header_latch_next = header_latch;
      first_error_next  = first_error;
      finished_next     = finished;
    end
  end

  // parsing state registers; buffer end returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      byte_count   <= '0;
      length_field <= '0;
      crc_register <= CRC_INIT;
      crc_trailer  <= '0;
      entry_shift  <= '0;
      header_latch <= '0;
      first_error  <= ST_OK;
      finished     <= 1'b0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      length_field <= length_field_next;
      crc_register <= crc_register_next;
      crc_trailer  <= crc_trailer_next;
      entry_shift  <= entry_shift_next;
      header_latch <= header_latch_next;
      first_error  <= first_error_next;
      finished     <= finished_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_transport_stream_pat_section_parser_core.sv =====
// Testbench for transport_stream_pat_section_parser_core.
// Depends on rtl/tspat_pkg.sv and the core; predicts every result in a scoreboard class
// and drives well-formed, damaged and random section buffers under random stalls.
`timescale 1ns / 1ps

module tb_transport_stream_pat_section_parser_core
  import tspat_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 250;
  localparam int DRAIN_CYCLES = 20;

  // one expected result, fields at the block's widths
  typedef struct packed {
    logic        kind;
    logic [15:0] prog_num;
    logic [12:0] pid;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    status_t     status;
    logic [12:0] consumed_bytes;
  } pat_result_t;

  // Scoreboard: parses the byte stream on its own and holds the expected results
  class pat_scoreboard;
    logic [12:0] byte_idx;
    logic [11:0] sec_len;
    logic [31:0] crc_acc;
    logic [31:0] crc_tail;
    logic [31:0] entry_sr;
    logic [39:0] hdr;
    status_t     err_code;
    bit          done;
    pat_result_t pending[$];
    int          errors;
    int          n_bytes;
    int          n_entries;
    int          n_status;
    int          status_seen[8];

    function new();
      errors = 0;
      n_bytes = 0;
      n_entries = 0;
      n_status = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear();
    endfunction

    function void clear();
      byte_idx = '0;
      sec_len  = '0;
      crc_acc  = CRC_INIT;
      crc_tail = '0;
      entry_sr = '0;
      hdr      = '0;
      err_code = ST_OK;
      done     = 1'b0;
    endfunction

    // CRC-32/MPEG-2, one byte, MSB first, bit-serial form
    static function logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] d);
      logic [31:0] c;
      c = c_in;
      for (int k = 7; k >= 0; k--) begin
        c = {c[30:0], 1'b0} ^ ((c[31] ^ d[k]) ? CRC_POLY : 32'h0);
      end
      return c;
    endfunction

    function pat_result_t status_result(status_t code);
      pat_result_t r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = code;
      if (code == ST_OK) begin
        r.stream_id          = hdr[39:24];
        r.version            = hdr[21:17];
        r.current_next       = hdr[16];
        r.section_index      = hdr[15:8];
        r.last_section_index = hdr[7:0];
        r.consumed_bytes     = {1'b0, sec_len} + 13'd3;
      end
      return r;
    endfunction

    // Notes one accepted input transaction; returns 1 if the block parses it
    function bit note_input(logic [7:0] b, logic last);
      int          idx;
      status_t     code;
      pat_result_t r;
      if (done) begin
        if (last) clear();
        return 1'b0;
      end
      n_bytes++;
      idx = byte_idx;
      byte_idx = byte_idx + 13'd1;

      // header bytes
      if (idx == 0) begin
        if (b != TABLE_ID_PAT) err_code = ST_TABLE_ID;
      end else if (idx == 1) begin
        if ((b & SYNTAX_MASK) != SYNTAX_VALUE) err_code = ST_SYNTAX;
        sec_len = {b[3:0], 8'h00};
      end else if (idx == 2) begin
        sec_len[7:0] = b;
        if (err_code == ST_OK && sec_len < MIN_LENGTH) err_code = ST_SHORT_LEN;
      end else if (idx <= 7) begin
        hdr = {hdr[31:0], b};
      end

      // running CRC over all but the trailing four bytes
      if (idx < 3 || idx + 1 < sec_len) crc_acc = crc_step(crc_acc, b);
      else crc_tail = {crc_tail[23:0], b};
      entry_sr = {entry_sr[23:0], b};

      if (err_code == ST_OK && idx >= 3 && idx == sec_len + 2) begin
        pending.push_back(status_result((crc_tail == crc_acc) ? ST_OK : ST_CRC));
        done = 1'b1;
      end else if (last) begin
        if (idx + 1 < 7) code = ST_SHORT_BUF;
        else if (err_code != ST_OK) code = err_code;
        else code = ST_SIZE;
        pending.push_back(status_result(code));
        done = 1'b1;
      end else if (err_code != ST_OK && idx + 1 >= 7) begin
        pending.push_back(status_result(err_code));
        done = 1'b1;
      end else if (err_code == ST_OK && idx >= 11 && ((idx - 8) & 3) == 3 &&
                   idx - 2 < sec_len) begin
        // program entry, may reach into the CRC bytes
        r = '0;
        r.kind = KIND_ENTRY;
        r.prog_num = entry_sr[31:16];
        r.pid = entry_sr[12:0];
        pending.push_back(r);
      end

      if (last) clear();
      return 1'b1;
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Checks one accepted result transaction against the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] d, logic k);
      pat_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d data %h", k, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("kind", e.kind, k);
      compare_field("prog_num", e.prog_num, d[15:0]);
      compare_field("pid", e.pid, d[28:16]);
      compare_field("stream_id", e.stream_id, d[44:29]);
      compare_field("version", e.version, d[49:45]);
      compare_field("current_next", e.current_next, d[50]);
      compare_field("section_index", e.section_index, d[58:51]);
      compare_field("last_section_index", e.last_section_index, d[66:59]);
      compare_field("status", e.status, d[69:67]);
      compare_field("consumed_bytes", e.consumed_bytes, d[82:70]);
      compare_field("zero pad", 0, d[87:83]);
      if (e.kind == KIND_STATUS) begin
        n_status++;
        status_seen[e.status]++;
      end else begin
        n_entries++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  pat_scoreboard sb;
  logic [7:0]    sec_bytes[$];
  int            send_idle = 10;
  int            recv_idle = 75;
  int            phase_bytes = 0;
  int            cycle_count = 0;

  transport_stream_pat_section_parser_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, check every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // one byte transaction with random gaps in front
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.note_input(b, last)) phase_bytes++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < sec_bytes.size(); i++) begin
      send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
    end
  endtask

  // well-formed section of the given length; fill < 0 gives random body bytes
  task automatic build_section(int slen, int fill);
    logic [31:0] c;
    int          total;
    total = slen + 3;
    sec_bytes.delete();
    sec_bytes.push_back(TABLE_ID_PAT);
    sec_bytes.push_back(SYNTAX_VALUE | 8'($urandom_range(3) << 4) | 8'((slen >> 8) & 15));
    sec_bytes.push_back(8'(slen));
    while (sec_bytes.size() < total - 4) begin
      sec_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    end
    c = CRC_INIT;
    foreach (sec_bytes[i]) c = pat_scoreboard::crc_step(c, sec_bytes[i]);
    sec_bytes.push_back(c[31:24]);
    sec_bytes.push_back(c[23:16]);
    sec_bytes.push_back(c[15:8]);
    sec_bytes.push_back(c[7:0]);
  endtask

  initial begin
    int         ph;
    int         sel;
    int         slen;
    int         cut;
    logic [7:0] top;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all-ones header and entry, a two-byte buffer, an early syntax error
    build_section(13, 8'hFF);
    send_buffer();
    sec_bytes = '{8'hFF, 8'h00};
    send_buffer();
    sec_bytes = '{8'hFF, 8'h4F, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
    send_buffer();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 10;
          recv_idle = 75;
        end
        1: begin
          send_idle = 75;
          recv_idle = 10;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        sel = $urandom_range(99);
        slen = 9 + 4 * (($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4));
        // entry area not a whole number of entries: the last entry runs into the CRC bytes
        if (sel >= 87 && sel < 94) slen = slen + $urandom_range(1, 3);
        // shortest legal sections, header overlaps the CRC
        if (sel >= 94 && sel < 97) slen = $urandom_range(5, 8);
        build_section(slen, -1);
        if (sel >= 55 && sel < 65) begin
          // damaged CRC trailer
          cut = sec_bytes.size() - 1 - $urandom_range(3);
          sec_bytes[cut] = sec_bytes[cut] ^ (8'h01 << $urandom_range(7));
        end else if (sel >= 65 && sel < 70) begin
          sec_bytes[0] = 8'($urandom_range(1, 255));
        end else if (sel >= 70 && sel < 75) begin
          top = ($urandom_range(2) == 2) ? 8'h03 : 8'($urandom_range(1));
          sec_bytes[1] = (sec_bytes[1] & 8'h3F) | (top << 6);
        end else if (sel >= 75 && sel < 80) begin
          sec_bytes[1] = sec_bytes[1] & 8'hF0;
          sec_bytes[2] = 8'($urandom_range(4));
        end else if (sel >= 80 && sel < 87) begin
          // buffer ends before the section does
          cut = $urandom_range(1) ? $urandom_range(1, 6) :
                                    $urandom_range(7, sec_bytes.size() - 1);
          while (sec_bytes.size() > cut) void'(sec_bytes.pop_back());
        end else if (sel >= 97) begin
          sec_bytes.delete();
          repeat ($urandom_range(1, 20)) sec_bytes.push_back(8'($urandom_range(255)));
          if ($urandom_range(1)) sec_bytes[0] = TABLE_ID_PAT;
        end
        // extra bytes at the buffer end, dropped by the block once a status has closed the buffer
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 6)) sec_bytes.push_back(8'($urandom_range(255)));
        end
        send_buffer();
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d parsed section bytes, %0d program entries, %0d closing statuses",
             sb.n_bytes, sb.n_entries, sb.n_status);
    $display({"Statuses: ok %0d, short buffer %0d, syntax %0d, table id %0d, ",
              "size %0d, crc %0d, short length %0d"},
             sb.status_seen[ST_OK], sb.status_seen[ST_SHORT_BUF], sb.status_seen[ST_SYNTAX],
             sb.status_seen[ST_TABLE_ID], sb.status_seen[ST_SIZE], sb.status_seen[ST_CRC],
             sb.status_seen[ST_SHORT_LEN]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tspat_pkg.sv
rtl/transport_stream_pat_section_parser_core.sv
test/tb_transport_stream_pat_section_parser_core.sv
